// ----- hw/rtl/ssm_pkg.sv -----
`timescale 1ns / 1ps

package ssm_pkg;

    localparam int SORT_KEY_W  = 32;
    localparam int ID_W        = 64;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_BOOLEAN_OP    = 2'd0;
    localparam logic [1:0] REG_LEFT_NEGATED  = 2'd1;
    localparam logic [1:0] REG_RIGHT_NEGATED = 2'd2;
    localparam logic [1:0] REG_KEYS_USED     = 2'd3;

    // boolean_op codes; the unused code behaves as XOR
    localparam logic [1:0] OP_AND = 2'd0;
    localparam logic [1:0] OP_OR  = 2'd1;
    localparam logic [1:0] OP_XOR = 2'd2;

    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    typedef struct packed {
        logic keep_left;
        logic keep_right;
        logic keep_both;
        logic negated;
    } merge_rule_t;

endpackage

// ----- hw/rtl/ssm_if.sv -----
`timescale 1ns / 1ps

interface ssm_in_if
    import ssm_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   side;
    logic                   is_end;
    logic [SORT_KEY_W-1:0]  sort_key;
    logic [ID_W-1:0]        rec_id;

    modport source (output valid, side, is_end, sort_key, rec_id, input ready);
    modport sink   (input valid, side, is_end, sort_key, rec_id, output ready);
endinterface

interface ssm_out_if
    import ssm_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   has_item;
    logic [SORT_KEY_W-1:0]  out_key;
    logic [ID_W-1:0]        out_id;
    logic                   done_res;
    logic                   result_negated;
    logic                   overflow;

    modport source (output valid, has_item, out_key, out_id, done_res, result_negated,
                    overflow, input ready);
    modport sink   (input valid, has_item, out_key, out_id, done_res, result_negated,
                    overflow, output ready);
endinterface

// ----- hw/rtl/sorted_set_merge_engine.sv -----
`timescale 1ns / 1ps
// An ignored item, a buffered item or a plain end leaves the block idle; an item decided at
// once passes through the emit state. A compared item retires buffered elements in turn, makes
// its last compare and, when it is then decided on its own, passes through the emit state. A
// flush retires every buffered element, then the final marker follows once both sides ended.
// A result shows on out_ch the cycle after it is decided; an untaken result in the output
// register stalls the next kept decision. Inputs are taken one at a time, only while idle. Reset
// (rst_n, async, active low) clears control and config state; the pending memory is not cleared.
module sorted_set_merge_engine
    import ssm_pkg::*;
#(
    parameter int PENDING_DEPTH = 32,
    parameter int KEY_WIDTH     = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    ssm_in_if.sink                in_ch,
    ssm_out_if.source             out_ch
);

    localparam int KW = (KEY_WIDTH < SORT_KEY_W) ? KEY_WIDTH : SORT_KEY_W;
    localparam int MW = KW + ID_W;
    localparam int PW = $clog2(PENDING_DEPTH);
    localparam int CW = $clog2(PENDING_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EMIT  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(PENDING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // ---------------- configuration registers ----------------
    logic [1:0] bool_op_reg;
    logic       left_neg_reg;
    logic       right_neg_reg;
    logic       keys_used_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bool_op_reg   <= OP_AND;
            left_neg_reg  <= 1'b0;
            right_neg_reg <= 1'b0;
            keys_used_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_BOOLEAN_OP:    bool_op_reg   <= pwdata[1:0];
                REG_LEFT_NEGATED:  left_neg_reg  <= pwdata[0];
                REG_RIGHT_NEGATED: right_neg_reg <= pwdata[0];
                REG_KEYS_USED:     keys_used_reg <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_BOOLEAN_OP:    prdata = APB_DATA_W'(bool_op_reg);
            REG_LEFT_NEGATED:  prdata = APB_DATA_W'(left_neg_reg);
            REG_RIGHT_NEGATED: prdata = APB_DATA_W'(right_neg_reg);
            REG_KEYS_USED:     prdata = APB_DATA_W'(keys_used_reg);
            default:           prdata = '0;
        endcase
    end

    // operation with negated operands folded into keep rules
    merge_rule_t rule;

    always_comb
    begin
        rule = '0;
        case (bool_op_reg)
            OP_AND:
            begin
                unique case ({left_neg_reg, right_neg_reg})
                    2'b00:   rule = '{keep_left: 1'b0, keep_right: 1'b0, keep_both: 1'b1,
                                      negated: 1'b0};
                    2'b01:   rule = '{keep_left: 1'b1, keep_right: 1'b0, keep_both: 1'b0,
                                      negated: 1'b0};
                    2'b10:   rule = '{keep_left: 1'b0, keep_right: 1'b1, keep_both: 1'b0,
                                      negated: 1'b0};
                    default: rule = '{keep_left: 1'b1, keep_right: 1'b1, keep_both: 1'b1,
                                      negated: 1'b1};
                endcase
            end
            OP_OR:
            begin
                unique case ({left_neg_reg, right_neg_reg})
                    2'b00:   rule = '{keep_left: 1'b1, keep_right: 1'b1, keep_both: 1'b1,
                                      negated: 1'b0};
                    2'b01:   rule = '{keep_left: 1'b0, keep_right: 1'b1, keep_both: 1'b0,
                                      negated: 1'b1};
                    2'b10:   rule = '{keep_left: 1'b1, keep_right: 1'b0, keep_both: 1'b0,
                                      negated: 1'b1};
                    default: rule = '{keep_left: 1'b0, keep_right: 1'b0, keep_both: 1'b1,
                                      negated: 1'b1};
                endcase
            end
            default:
                rule = '{keep_left: 1'b1, keep_right: 1'b1, keep_both: 1'b0,
                         negated: left_neg_reg ^ right_neg_reg};
        endcase
    end

    // ---------------- control and pending state ----------------
    logic [2:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [PW-1:0]          head_reg, head_next;
    logic [PW-1:0]          tail_reg, tail_next;
    logic                   pside_reg, pside_next;
    logic                   left_end_reg, left_end_next;
    logic                   right_end_reg, right_end_next;
    logic                   ovf_reg, ovf_next;
    logic                   final_reg, final_next;

    logic                   item_side_reg, item_side_next;
    logic [KW-1:0]          item_key_reg, item_key_next;
    logic [ID_W-1:0]        item_id_reg, item_id_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_has_reg;
    logic [KW-1:0]          out_key_reg;
    logic [ID_W-1:0]        out_id_reg;
    logic                   out_done_reg;
    logic                   out_neg_reg;
    logic                   out_ovf_reg;

    // pending memory, read address is the next head so read data tracks the head entry
    logic [MW-1:0]          pend_mem [PENDING_DEPTH];
    logic [MW-1:0]          rd_raw_reg;
    logic [MW-1:0]          fwd_data_reg;
    logic                   fwd_reg;
    logic [MW-1:0]          rd_word;
    logic                   mem_we;
    logic [MW-1:0]          mem_wdata;

    logic [KW-1:0]          head_key;
    logic [ID_W-1:0]        head_id;
    logic [KW-1:0]          in_key;
    logic                   in_fire;
    logic                   in_own_end;
    logic                   in_other_end;
    logic                   item_other_end;
    logic                   keep_pside;
    logic                   keep_item;
    logic                   head_lt_item;
    logic                   item_lt_head;
    logic                   buf_full;
    logic                   can_emit;

    logic                   emit;
    logic                   emit_has;
    logic [KW-1:0]          emit_key;
    logic [ID_W-1:0]        emit_id;
    logic                   emit_done;
    logic                   push;
    logic                   push_side;
    logic [KW-1:0]          push_key;
    logic [ID_W-1:0]        push_id;
    logic                   pop;

    assign rd_word  = fwd_reg ? fwd_data_reg : rd_raw_reg;
    assign head_key = rd_word[MW-1:ID_W];
    assign head_id  = rd_word[ID_W-1:0];
    assign in_key   = in_ch.sort_key[KW-1:0];

    assign in_ch.ready    = (state_reg == S_IDLE);
    assign in_fire        = in_ch.valid && in_ch.ready;
    assign in_own_end     = (in_ch.side == SIDE_RIGHT) ? right_end_reg : left_end_reg;
    assign in_other_end   = (in_ch.side == SIDE_RIGHT) ? left_end_reg : right_end_reg;
    assign item_other_end = (item_side_reg == SIDE_RIGHT) ? left_end_reg : right_end_reg;
    assign keep_pside     = (pside_reg == SIDE_RIGHT) ? rule.keep_right : rule.keep_left;
    assign keep_item      = (item_side_reg == SIDE_RIGHT) ? rule.keep_right : rule.keep_left;
    assign buf_full       = (count_reg == CW'(PENDING_DEPTH));
    assign can_emit       = !out_valid_reg || out_ch.ready;

    // (key, id) ordering; without keys all keys compare equal
    always_comb
    begin
        if (keys_used_reg)
        begin
            head_lt_item = (head_key < item_key_reg) ||
                           ((head_key == item_key_reg) && (head_id < item_id_reg));
            item_lt_head = (item_key_reg < head_key) ||
                           ((item_key_reg == head_key) && (item_id_reg < head_id));
        end
        else
        begin
            head_lt_item = head_id < item_id_reg;
            item_lt_head = item_id_reg < head_id;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        pside_next     = pside_reg;
        left_end_next  = left_end_reg;
        right_end_next = right_end_reg;
        ovf_next       = ovf_reg;
        final_next     = final_reg;
        item_side_next = item_side_reg;
        item_key_next  = item_key_reg;
        item_id_next   = item_id_reg;
        emit           = 1'b0;
        emit_has       = 1'b1;
        emit_key       = item_key_reg;
        emit_id        = item_id_reg;
        emit_done      = 1'b0;
        push           = 1'b0;
        push_side      = item_side_reg;
        push_key       = item_key_reg;
        push_id        = item_id_reg;
        pop            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && !in_own_end)
                begin
                    item_side_next = in_ch.side;
                    item_key_next  = in_key;
                    item_id_next   = in_ch.rec_id;
                    if (in_ch.is_end)
                    begin
                        if (in_ch.side == SIDE_RIGHT)
                            right_end_next = 1'b1;
                        else
                            left_end_next = 1'b1;
                        if (in_other_end)
                        begin
                            final_next = 1'b1;
                            state_next = S_FLUSH;
                        end
                        else if (count_reg != '0 && pside_reg != in_ch.side)
                            state_next = S_FLUSH;
                    end
                    else if (in_other_end && (count_reg == '0 || pside_reg == in_ch.side))
                        state_next = S_EMIT;
                    else if (count_reg != '0 && pside_reg != in_ch.side)
                        state_next = S_CMP;
                    else
                    begin
                        push      = 1'b1;
                        push_side = in_ch.side;
                        push_key  = in_key;
                        push_id   = in_ch.rec_id;
                    end
                end
            end
            S_EMIT:
            begin
                if (!keep_item)
                    state_next = S_IDLE;
                else if (can_emit)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CMP:
            begin
                if (count_reg == '0)
                begin
                    if (item_other_end)
                        state_next = S_EMIT;
                    else
                    begin
                        push       = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (head_lt_item)
                begin
                    if (!keep_pside || can_emit)
                    begin
                        emit     = keep_pside;
                        emit_key = head_key;
                        emit_id  = head_id;
                        pop      = 1'b1;
                    end
                end
                else if (item_lt_head)
                    state_next = S_EMIT;
                else if (!rule.keep_both || can_emit)
                begin
                    // equal element: the left copy is the one reported
                    emit = rule.keep_both;
                    if (pside_reg == SIDE_LEFT)
                    begin
                        emit_key = head_key;
                        emit_id  = head_id;
                    end
                    pop        = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (count_reg == '0)
                    state_next = final_reg ? S_FINAL : S_IDLE;
                else if (!keep_pside || can_emit)
                begin
                    emit     = keep_pside;
                    emit_key = head_key;
                    emit_id  = head_id;
                    pop      = 1'b1;
                end
            end
            S_FINAL:
            begin
                if (can_emit)
                begin
                    emit           = 1'b1;
                    emit_has       = 1'b0;
                    emit_key       = '0;
                    emit_id        = '0;
                    emit_done      = 1'b1;
                    count_next     = '0;
                    pside_next     = SIDE_LEFT;
                    left_end_next  = 1'b0;
                    right_end_next = 1'b0;
                    ovf_next       = 1'b0;
                    final_next     = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (pop)
        begin
            count_next = count_reg - 1'b1;
            head_next  = ptr_inc(head_reg);
        end

        if (push)
        begin
            if (buf_full)
                ovf_next = 1'b1;
            else
            begin
                pside_next = push_side;
                count_next = count_reg + 1'b1;
                tail_next  = ptr_inc(tail_reg);
            end
        end
    end

    assign mem_we    = push && !buf_full;
    assign mem_wdata = {push_key, push_id};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            pend_mem[tail_reg] <= mem_wdata;
    end

    // same-cycle write to the entry being read is forwarded
    always_ff @(posedge clk)
    begin
        rd_raw_reg   <= pend_mem[head_next];
        fwd_reg      <= mem_we && (tail_reg == head_next);
        fwd_data_reg <= mem_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            pside_reg     <= SIDE_LEFT;
            left_end_reg  <= 1'b0;
            right_end_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            pside_reg     <= pside_next;
            left_end_reg  <= left_end_next;
            right_end_reg <= right_end_next;
            ovf_reg       <= ovf_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_side_reg <= item_side_next;
        item_key_reg  <= item_key_next;
        item_id_reg   <= item_id_next;
        if (emit)
        begin
            out_has_reg  <= emit_has;
            out_key_reg  <= emit_key;
            out_id_reg   <= emit_id;
            out_done_reg <= emit_done;
            out_neg_reg  <= rule.negated;
            out_ovf_reg  <= ovf_reg;
        end
    end

    // ---------------- output transaction ----------------
    assign out_valid_next = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.has_item       = out_has_reg;
    assign out_ch.out_key        = SORT_KEY_W'(out_key_reg);
    assign out_ch.out_id         = out_id_reg;
    assign out_ch.done_res       = out_done_reg;
    assign out_ch.result_negated = out_neg_reg;
    assign out_ch.overflow       = out_ovf_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(PENDING_DEPTH))
        else $error("pending count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0) && !push)
        else $error("pop from empty pending buffer");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> can_emit)
        else $error("result overwrote an untaken transaction");

    a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINAL && can_emit) |=>
            (count_reg == '0) && !left_end_reg && !right_end_reg && !ovf_reg
            && out_valid_reg && out_done_reg)
        else $error("final marker did not clear merge state");

endmodule

// ----- tb/tb_sorted_set_merge_engine.sv -----
`timescale 1ns / 1ps

module tb_sorted_set_merge_engine
    import ssm_pkg::*;
();

    localparam int PENDING_DEPTH  = 32;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int REPORT_LIMIT   = 10;
    // spare boolean_op code, behaves as XOR
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct {
        logic                   side;
        logic                   is_end;
        logic [SORT_KEY_W-1:0]  key;
        logic [ID_W-1:0]        id;
    } merge_item_t;

    typedef struct {
        logic                   has_item;
        logic [SORT_KEY_W-1:0]  key;
        logic [ID_W-1:0]        id;
        logic                   done;
        logic                   neg;
        logic                   ovf;
    } merge_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ssm_in_if  in_ch ();
    ssm_out_if out_ch ();

    sorted_set_merge_engine #(
        .PENDING_DEPTH(PENDING_DEPTH),
        .KEY_WIDTH    (SORT_KEY_W)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // register shadows, reset values
    logic [1:0]  op_sel    = OP_AND;
    logic        neg_left  = 1'b0;
    logic        neg_right = 1'b0;
    logic        use_keys  = 1'b1;

    // merge state shadow
    merge_item_t held[$];
    logic        held_side    = SIDE_LEFT;
    logic        left_closed  = 1'b0;
    logic        right_closed = 1'b0;
    logic        dropped_flag = 1'b0;
    merge_rule_t rule;

    merge_item_t   input_items[$];
    merge_result_t expected_results[$];
    merge_item_t   universe[$];
    merge_item_t   left_list[$];
    merge_item_t   right_list[$];
    merge_item_t   cur_item;

    int items_queued   = 0;
    int items_accepted = 0;
    int mismatches     = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int idle_cycles    = 0;

    function automatic bit rec_lt(input logic [SORT_KEY_W-1:0] ka,
                                  input logic [ID_W-1:0] ia,
                                  input logic [SORT_KEY_W-1:0] kb,
                                  input logic [ID_W-1:0] ib);
        if (use_keys && ka != kb)
        begin
            return ka < kb;
        end
        return ia < ib;
    endfunction

    function automatic void emit_result(input logic has, input logic [SORT_KEY_W-1:0] k,
                                        input logic [ID_W-1:0] i, input logic dn);
        merge_result_t r;
        r.has_item = has;
        r.key      = k;
        r.id       = i;
        r.done     = dn;
        r.neg      = rule.negated;
        r.ovf      = dropped_flag;
        expected_results.insert(expected_results.size(), r);
    endfunction

    // element whose membership is known to be one side only
    function automatic void decide_single(input logic s, input logic [SORT_KEY_W-1:0] k,
                                          input logic [ID_W-1:0] i);
        if (s == SIDE_RIGHT ? rule.keep_right : rule.keep_left)
        begin
            emit_result(1'b1, k, i, 1'b0);
        end
    endfunction

    function automatic void flush_held();
        foreach (held[j])
        begin
            decide_single(held_side, held[j].key, held[j].id);
        end
        held.delete();
    endfunction

    function automatic void hold_element(input merge_item_t it);
        if (held.size() >= PENDING_DEPTH)
        begin
            dropped_flag = 1'b1;
        end
        else
        begin
            held_side = it.side;
            held.insert(held.size(), it);
        end
    endfunction

    function automatic void predict_merge(input merge_item_t it);
        logic own_end;
        logic other_end;
        merge_item_t head;

        rule = '0;
        case (op_sel)
            OP_AND:
            begin
                if (!neg_left && !neg_right)
                    rule.keep_both = 1'b1;
                else if (!neg_left)
                    rule.keep_left = 1'b1;
                else if (!neg_right)
                    rule.keep_right = 1'b1;
                else
                    rule = '{keep_left: 1'b1, keep_right: 1'b1, keep_both: 1'b1,
                             negated: 1'b1};
            end
            OP_OR:
            begin
                if (!neg_left && !neg_right)
                    rule = '{keep_left: 1'b1, keep_right: 1'b1, keep_both: 1'b1,
                             negated: 1'b0};
                else if (!neg_left)
                    rule = '{keep_left: 1'b0, keep_right: 1'b1, keep_both: 1'b0,
                             negated: 1'b1};
                else if (!neg_right)
                    rule = '{keep_left: 1'b1, keep_right: 1'b0, keep_both: 1'b0,
                             negated: 1'b1};
                else
                    rule = '{keep_left: 1'b0, keep_right: 1'b0, keep_both: 1'b1,
                             negated: 1'b1};
            end
            default:
            begin
                rule = '{keep_left: 1'b1, keep_right: 1'b1, keep_both: 1'b0,
                         negated: neg_left ^ neg_right};
            end
        endcase

        own_end   = (it.side == SIDE_RIGHT) ? right_closed : left_closed;
        other_end = (it.side == SIDE_RIGHT) ? left_closed : right_closed;
        if (own_end)
        begin
            return;
        end

        if (it.is_end)
        begin
            if (it.side == SIDE_RIGHT)
                right_closed = 1'b1;
            else
                left_closed = 1'b1;
            if (other_end)
            begin
                flush_held();
                emit_result(1'b0, '0, '0, 1'b1);
                held_side    = SIDE_LEFT;
                left_closed  = 1'b0;
                right_closed = 1'b0;
                dropped_flag = 1'b0;
            end
            else if (held.size() > 0 && held_side != it.side)
            begin
                flush_held();
            end
            return;
        end

        if (other_end && (held.size() == 0 || held_side == it.side))
        begin
            decide_single(it.side, it.key, it.id);
            return;
        end

        if (held.size() > 0 && held_side == it.side)
        begin
            hold_element(it);
            return;
        end

        while (held.size() > 0)
        begin
            head = held[0];
            if (rec_lt(head.key, head.id, it.key, it.id))
            begin
                decide_single(held_side, head.key, head.id);
                void'(held.pop_front());
            end
            else if (rec_lt(it.key, it.id, head.key, head.id))
            begin
                decide_single(it.side, it.key, it.id);
                return;
            end
            else
            begin
                // present in both: left copy wins
                if (rule.keep_both)
                begin
                    if (held_side == SIDE_LEFT)
                        emit_result(1'b1, head.key, head.id, 1'b0);
                    else
                        emit_result(1'b1, it.key, it.id, 1'b0);
                end
                void'(held.pop_front());
                return;
            end
        end

        if (other_end)
        begin
            decide_single(it.side, it.key, it.id);
            return;
        end
        hold_element(it);
    endfunction

    // ---------------- driver ----------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_merge(cur_item);
                items_accepted++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    in_ch.valid <= 1'b0;
                    gap_left--;
                end
                else if (input_items.size() > 0)
                begin
                    cur_item = input_items.pop_front();
                    in_ch.valid    <= 1'b1;
                    in_ch.side     <= cur_item.side;
                    in_ch.is_end   <= cur_item.is_end;
                    in_ch.sort_key <= cur_item.key;
                    in_ch.rec_id   <= cur_item.id;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                                  : $urandom_range(1, 8);
                        gap_left   = $urandom_range(1, 7);
                    end
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver stall pattern ----------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (stall_left == 0)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 6);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                stall_left = $urandom_range(1, 30);
            end
        end
        else
        begin
            stall_left--;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        merge_result_t want;
        merge_result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.has_item = out_ch.has_item;
            got.key      = out_ch.out_key;
            got.id       = out_ch.out_id;
            got.done     = out_ch.done_res;
            got.neg      = out_ch.result_negated;
            got.ovf      = out_ch.overflow;
            if (expected_results.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("[%0t] unexpected: has=%0b key=%h id=%h done=%0b neg=%0b ovf=%0b",
                             $realtime, got.has_item, got.key, got.id, got.done, got.neg,
                             got.ovf);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.has_item !== want.has_item || got.key !== want.key ||
                    got.id !== want.id || got.done !== want.done ||
                    got.neg !== want.neg || got.ovf !== want.ovf)
                begin
                    if (mismatches < REPORT_LIMIT)
                    begin
                        $display("[%0t] exp has=%0b key=%h id=%h done=%0b neg=%0b ovf=%0b",
                                 $realtime, want.has_item, want.key, want.id, want.done,
                                 want.neg, want.ovf);
                        $display("      got has=%0b key=%h id=%h done=%0b neg=%0b ovf=%0b",
                                 got.has_item, got.key, got.id, got.done, got.neg, got.ovf);
                    end
                    mismatches++;
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic apb_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_BOOLEAN_OP:    op_sel    = val[1:0];
            REG_LEFT_NEGATED:  neg_left  = val[0];
            REG_RIGHT_NEGATED: neg_right = val[0];
            REG_KEYS_USED:     use_keys  = val[0];
            default:           ;
        endcase
    endtask

    task automatic set_config(input logic [1:0] op, input logic ln, input logic rn,
                              input logic ku);
        apb_write(REG_BOOLEAN_OP, {30'd0, op});
        apb_write(REG_LEFT_NEGATED, {31'd0, ln});
        apb_write(REG_RIGHT_NEGATED, {31'd0, rn});
        apb_write(REG_KEYS_USED, {31'd0, ku});
    endtask

    task automatic queue_item(input logic s, input logic e, input logic [SORT_KEY_W-1:0] k,
                              input logic [ID_W-1:0] i);
        merge_item_t it;
        it.side   = s;
        it.is_end = e;
        it.key    = k;
        it.id     = i;
        input_items.insert(input_items.size(), it);
        items_queued++;
    endtask

    // end of a side, optionally followed by an item that must be ignored
    task automatic close_side(input logic s, input bit other_closed);
        queue_item(s, 1'b1, $urandom(), {$urandom(), $urandom()});
        if (!other_closed && $urandom_range(0, 2) == 0)
        begin
            if ($urandom_range(0, 1))
                queue_item(s, 1'b1, $urandom(), {$urandom(), $urandom()});
            else
                queue_item(s, 1'b0, $urandom(), {$urandom(), $urandom()});
        end
    endtask

    function automatic logic [SORT_KEY_W-1:0] pick_key();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return SORT_KEY_W'($urandom_range(0, 4));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return ID_W'($urandom_range(0, 8));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic insert_sorted(input merge_item_t r);
        int pos;
        pos = 0;
        while (pos < universe.size() && rec_lt(universe[pos].key, universe[pos].id, r.key, r.id))
            pos++;
        if (pos < universe.size() && !rec_lt(r.key, r.id, universe[pos].key, universe[pos].id))
            return;
        universe.insert(pos, r);
    endtask

    // one stream pair: two ascending lists, interleaved, both sides closed
    task automatic build_phase(input bit long_left, output int real_items);
        merge_item_t r;
        int n;
        int li;
        int ri;
        int mode;
        int roll;
        bit take_left;
        bit l_closed;
        bit r_closed;

        universe.delete();
        left_list.delete();
        right_list.delete();
        real_items = 0;
        n = long_left ? $urandom_range(34, 38) : $urandom_range(1, 12);
        repeat (n)
        begin
            r.side   = SIDE_LEFT;
            r.is_end = 1'b0;
            r.key    = pick_key();
            r.id     = pick_id();
            insert_sorted(r);
        end
        foreach (universe[j])
        begin
            r = universe[j];
            roll = long_left ? ((j % 8 == 7) ? 9 : 0) : $urandom_range(0, 9);
            if (roll <= 3 || roll >= 7)
            begin
                r.side = SIDE_LEFT;
                left_list.insert(left_list.size(), r);
            end
            if (roll >= 4)
            begin
                r.side = SIDE_RIGHT;
                // id-only order: a shared id may carry a different key on the right
                if (!use_keys && roll >= 7 && $urandom_range(0, 1))
                    r.key = pick_key();
                right_list.insert(right_list.size(), r);
            end
        end

        mode = long_left ? 1 : $urandom_range(0, 2);
        li = 0;
        ri = 0;
        l_closed = 1'b0;
        r_closed = 1'b0;
        while (li < left_list.size() || ri < right_list.size())
        begin
            case (mode)
                0:       take_left = $urandom_range(0, 1);
                1:       take_left = li < left_list.size();
                default: take_left = ri >= right_list.size();
            endcase
            if (li >= left_list.size())
                take_left = 1'b0;
            if (ri >= right_list.size())
                take_left = 1'b1;
            if (take_left)
            begin
                r = left_list[li];
                li++;
            end
            else
            begin
                r = right_list[ri];
                ri++;
            end
            queue_item(r.side, 1'b0, r.key, r.id);
            real_items++;
            if (!l_closed && li == left_list.size() && $urandom_range(0, 1))
            begin
                close_side(SIDE_LEFT, r_closed);
                l_closed = 1'b1;
            end
            if (!r_closed && ri == right_list.size() && $urandom_range(0, 1))
            begin
                close_side(SIDE_RIGHT, l_closed);
                r_closed = 1'b1;
            end
        end
        if ($urandom_range(0, 1))
        begin
            if (!l_closed)
            begin
                close_side(SIDE_LEFT, r_closed);
                l_closed = 1'b1;
            end
            if (!r_closed)
                close_side(SIDE_RIGHT, l_closed);
        end
        else
        begin
            if (!r_closed)
            begin
                close_side(SIDE_RIGHT, l_closed);
                r_closed = 1'b1;
            end
            if (!l_closed)
                close_side(SIDE_LEFT, r_closed);
        end
        real_items += 2;
    endtask

    // wait until the block has gone quiet
    task automatic finish_phase();
        while (items_accepted != items_queued)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // ---------------- main sequence ----------------
    initial
    begin
        int p;
        int count;
        int got_items;

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_ch.valid    = 1'b0;
        in_ch.side     = SIDE_LEFT;
        in_ch.is_end   = 1'b0;
        in_ch.sort_key = '0;
        in_ch.rec_id   = '0;
        out_ch.ready   = 1'b0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        // reset config: AND, keys compared
        queue_item(SIDE_LEFT, 1'b0, 32'd0, 64'd0);
        queue_item(SIDE_RIGHT, 1'b0, 32'd0, 64'd0);             // shared element
        queue_item(SIDE_RIGHT, 1'b0, 32'd3, 64'd9);
        queue_item(SIDE_LEFT, 1'b0, 32'd3, 64'd8);
        queue_item(SIDE_LEFT, 1'b0, 32'd3, 64'd9);
        queue_item(SIDE_LEFT, 1'b0, 32'd7, 64'd1);
        queue_item(SIDE_LEFT, 1'b0, 32'd6, 64'd2);              // out of order
        queue_item(SIDE_RIGHT, 1'b0, '1, '1);
        queue_item(SIDE_LEFT, 1'b1, $urandom(), {$urandom(), $urandom()});
        queue_item(SIDE_LEFT, 1'b0, 32'd1, 64'd1);              // after its end
        queue_item(SIDE_LEFT, 1'b1, $urandom(), {$urandom(), $urandom()});
        queue_item(SIDE_RIGHT, 1'b0, 32'd5, 64'd5);             // other side closed
        queue_item(SIDE_RIGHT, 1'b1, $urandom(), {$urandom(), $urandom()});
        finish_phase();

        // spare op code, left negated, id-only order
        set_config(OP_SPARE, 1'b1, 1'b0, 1'b0);
        queue_item(SIDE_RIGHT, 1'b0, 32'd2, 64'd5);
        queue_item(SIDE_RIGHT, 1'b0, '1, 64'd6);
        queue_item(SIDE_LEFT, 1'b0, 32'd0, 64'd6);
        queue_item(SIDE_RIGHT, 1'b0, 32'd9, 64'd7);
        queue_item(SIDE_LEFT, 1'b1, $urandom(), {$urandom(), $urandom()});  // flushes right
        queue_item(SIDE_RIGHT, 1'b0, 32'd1, '1);
        queue_item(SIDE_RIGHT, 1'b1, $urandom(), {$urandom(), $urandom()});
        finish_phase();

        set_config(OP_OR, 1'b1, 1'b1, 1'b1);
        queue_item(SIDE_RIGHT, 1'b0, 32'd1, 64'd1);
        queue_item(SIDE_LEFT, 1'b0, 32'd1, 64'd1);
        queue_item(SIDE_RIGHT, 1'b1, $urandom(), {$urandom(), $urandom()});
        queue_item(SIDE_LEFT, 1'b1, $urandom(), {$urandom(), $urandom()});
        finish_phase();

        p = 0;
        count = items_queued;
        while (count < 210 || p < 16)
        begin
            set_config(p[1:0], p[2], p[3], (p % 3) != 2);
            build_phase((p % 9) == 4, got_items);
            count += got_items;
            finish_phase();
            p++;
        end

        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ssm_pkg.sv
hw/rtl/ssm_if.sv
hw/rtl/sorted_set_merge_engine.sv
tb/tb_sorted_set_merge_engine.sv
